// ===== hdl/m3op_pkg.sv =====
// Shared types, codes and helpers for the 3x3 matrix operation unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package m3op_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int VALUE_WIDTH    = 49;
  localparam int NUM_ELEMS      = 9;
  localparam int ADDR_WIDTH     = 4;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_MUL  = 3'd1;
  localparam logic [2:0] CMD_ADD  = 3'd2;
  localparam logic [2:0] CMD_SUB  = 3'd3;
  localparam logic [2:0] CMD_DET  = 3'd4;
  localparam logic [2:0] CMD_TRN  = 3'd5;

  localparam logic [1:0] IDX_LAST = 2'd2;
  localparam logic [1:0] IDX_BAD  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_HOLD,
    DP_PROD,
    DP_MINOR,
    DP_DMAC,
    DP_MAC,
    DP_ADD,
    DP_SUB,
    DP_COPY,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic                  sel;
    logic [ADDR_WIDTH-1:0] addr_a;
    logic [ADDR_WIDTH-1:0] addr_b;
    logic                  first;
    logic                  neg;
    logic                  wr_en;
    logic                  wr_mat;
    logic [ADDR_WIDTH-1:0] wr_addr;
    logic                  out_src;
    logic [1:0]            out_row;
    logic [1:0]            out_col;
    logic                  out_last;
  } dp_cmd_t;

  // Row-major position of an element: row * 3 + col.
  function automatic logic [ADDR_WIDTH-1:0] elem_addr(input logic [1:0] row,
                                                      input logic [1:0] col);
    return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
  endfunction

  // Element read at each step of one cofactor term: the two products of the
  // minor (p, q and s, t) and then the first-row coefficient.
  function automatic logic [ADDR_WIDTH-1:0] det_addr(input logic [1:0] term,
                                                     input logic [2:0] sub);
    logic [ADDR_WIDTH-1:0] a;
    a = '0;
    case (term)
      2'd0: begin
        case (sub)
          3'd0: a = 4'd4;
          3'd1: a = 4'd8;
          3'd2: a = 4'd7;
          3'd3: a = 4'd5;
          default: a = 4'd0;
        endcase
      end
      2'd1: begin
        case (sub)
          3'd0: a = 4'd3;
          3'd1: a = 4'd8;
          3'd2: a = 4'd5;
          3'd3: a = 4'd6;
          default: a = 4'd1;
        endcase
      end
      default: begin
        case (sub)
          3'd0: a = 4'd3;
          3'd1: a = 4'd7;
          3'd2: a = 4'd4;
          3'd3: a = 4'd6;
          default: a = 4'd2;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/matrix3_op_unit.sv =====
// Top level of the 3x3 matrix operation unit: stream ports around the
// sequencer and the datapath. Depends on m3op_pkg, m3op_ctrl, m3op_dpath.
//
//   channel | direction | carries
//   s_*     | in        | load item or operation command
//   m_*     | out       | result element or determinant, run end on tlast
//
// A load is written into its matrix when it is accepted. An operation is
// accepted, then each result is calculated and moved into the output register.
// The calculation time of each operation follows from one shared multiplier
// and one read port per matrix.
// Reset clears both matrices to zero and empties the output register.
// A stalled result transfer holds the sequencer; no new item is taken mid-run.
`timescale 1ns / 1ps

module matrix3_op_unit
  import m3op_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row_index[1:0], col_index[3:2], elem_value[19:4]
  input  logic [3:0]  s_tuser,   // cmd[2:0], which_matrix[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_row[1:0], out_col[3:2], out_value[52:4]
  output logic [0:0]  m_tuser,   // source_matrix[0]
  output logic        m_tlast
);

  dp_cmd_t                       cmd;
  logic                          out_free;
  logic                          out_src;
  logic [1:0]                    out_row;
  logic [1:0]                    out_col;
  logic signed [VALUE_WIDTH-1:0] out_value;

  m3op_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_cmd   (s_tuser[2:0]),
    .in_which (s_tuser[3]),
    .in_row   (s_tdata[1:0]),
    .in_col   (s_tdata[3:2]),
    .out_free (out_free),
    .cmd      (cmd)
  );

  m3op_dpath #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .elem_value (s_tdata[19:4]),
    .out_free   (out_free),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_src    (out_src),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (m_tlast)
  );

  assign m_tdata = {3'b000, out_value, out_col, out_row};
  assign m_tuser = out_src;

endmodule

// ===== hdl/m3op_ctrl.sv =====
// Sequencer of the 3x3 matrix operation unit: walks result elements and
// micro-steps, and issues datapath commands. Depends on m3op_pkg.
`timescale 1ns / 1ps

module m3op_ctrl
  import m3op_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [2:0] in_cmd,
  input  logic       in_which,
  input  logic [1:0] in_row,
  input  logic [1:0] in_col,
  input  logic       out_free,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;
  logic [2:0] op, op_next;
  logic [1:0] row, row_next;
  logic [1:0] col, col_next;
  logic       mat, mat_next;
  logic [2:0] sub, sub_next;
  logic [1:0] term, term_next;

  logic is_op;
  logic calc_done;
  logic run_last;
  logic corner;

  assign is_op  = (in_cmd >= CMD_MUL) && (in_cmd <= CMD_TRN);
  assign corner = (row == IDX_LAST) && (col == IDX_LAST);

  always_comb begin
    case (op)
      CMD_MUL: calc_done = (sub == 3'd2);
      CMD_DET: calc_done = (sub == 3'd4) && (term == 2'd2);
      default: calc_done = 1'b1;
    endcase
  end

  always_comb begin
    case (op)
      CMD_DET: run_last = mat;
      CMD_TRN: run_last = mat && corner;
      default: run_last = corner;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= CMD_LOAD;
      row   <= '0;
      col   <= '0;
      mat   <= 1'b0;
      sub   <= '0;
      term  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      row   <= row_next;
      col   <= col_next;
      mat   <= mat_next;
      sub   <= sub_next;
      term  <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    row_next   = row;
    col_next   = col;
    mat_next   = mat;
    sub_next   = sub;
    term_next  = term;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && is_op) begin
          state_next = ST_CALC;
          op_next    = in_cmd;
          row_next   = '0;
          col_next   = '0;
          mat_next   = 1'b0;
          sub_next   = '0;
          term_next  = '0;
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          state_next = ST_EMIT;
          sub_next   = '0;
          term_next  = '0;
        end else if ((op == CMD_DET) && (sub == 3'd4)) begin
          sub_next  = '0;
          term_next = term + 2'd1;
        end else begin
          sub_next = sub + 3'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (run_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_CALC;
            if (op == CMD_DET) begin
              mat_next = 1'b1;
            end else if (col == IDX_LAST) begin
              col_next = '0;
              if (row == IDX_LAST) begin
                row_next = '0;
                mat_next = 1'b1;
              end else begin
                row_next = row + 2'd1;
              end
            end else begin
              col_next = col + 2'd1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = DP_NOP;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No transfer is taken while reset is held.
        s_tready    = !rst;
        cmd.wr_en   = s_tvalid && (in_cmd == CMD_LOAD) &&
                      (in_row != IDX_BAD) && (in_col != IDX_BAD);
        cmd.wr_mat  = in_which;
        cmd.wr_addr = elem_addr(in_row, in_col);
      end
      ST_CALC: begin
        unique case (op)
          CMD_MUL: begin
            cmd.op     = DP_MAC;
            cmd.addr_a = elem_addr(row, sub[1:0]);
            cmd.addr_b = elem_addr(sub[1:0], col);
            cmd.first  = (sub == 3'd0);
          end
          CMD_ADD, CMD_SUB: begin
            cmd.op     = (op == CMD_ADD) ? DP_ADD : DP_SUB;
            cmd.addr_a = elem_addr(row, col);
            cmd.addr_b = elem_addr(row, col);
          end
          CMD_TRN: begin
            cmd.op     = DP_COPY;
            cmd.sel    = mat;
            cmd.addr_a = elem_addr(col, row);
            cmd.addr_b = elem_addr(col, row);
          end
          CMD_DET: begin
            cmd.sel    = mat;
            cmd.addr_a = det_addr(term, sub);
            cmd.addr_b = det_addr(term, sub);
            cmd.first  = (term == 2'd0);
            cmd.neg    = (term == 2'd1);
            case (sub)
              3'd0, 3'd2: cmd.op = DP_HOLD;
              3'd1:       cmd.op = DP_PROD;
              3'd3:       cmd.op = DP_MINOR;
              default:    cmd.op = DP_DMAC;
            endcase
          end
          default: cmd.op = DP_NOP;
        endcase
      end
      ST_EMIT: begin
        cmd.op       = out_free ? DP_EMIT : DP_NOP;
        cmd.out_src  = ((op == CMD_DET) || (op == CMD_TRN)) ? mat : 1'b0;
        cmd.out_row  = (op == CMD_DET) ? 2'd0 : row;
        cmd.out_col  = (op == CMD_DET) ? 2'd0 : col;
        cmd.out_last = run_last;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_EMIT) |-> out_free)
    else $error("result transfer issued while the output register is occupied");

  a_op_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && s_tvalid && is_op) |=> (state == ST_CALC))
    else $error("accepted operation did not start a calculation");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_EMIT && cmd.out_last) |=> (state == ST_IDLE))
    else $error("run did not end after its final result");

  a_det_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && op == CMD_DET) |-> (sub <= 3'd4 && term <= 2'd2))
    else $error("determinant sequencer out of range");
`endif

endmodule

// ===== hdl/m3op_dpath.sv =====
// Datapath of the 3x3 matrix operation unit: element registers, one shared
// multiplier, accumulator and output register. Depends on m3op_pkg.
`timescale 1ns / 1ps

module m3op_dpath
  import m3op_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  input  logic [15:0]                   elem_value,
  output logic                          out_free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          out_src,
  output logic [1:0]                    out_row,
  output logic [1:0]                    out_col,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic                          out_last
);

  localparam int YW = 2 * ELEM_WIDTH + 1;
  localparam int MW = 3 * ELEM_WIDTH + 1;

  logic signed [ELEM_WIDTH-1:0]   mat_a [NUM_ELEMS];
  logic signed [ELEM_WIDTH-1:0]   mat_b [NUM_ELEMS];
  logic signed [ELEM_WIDTH-1:0]   rd_a, rd_b, x;
  logic signed [YW-1:0]           y;
  logic signed [MW-1:0]           mul;
  logic signed [ELEM_WIDTH-1:0]   hold;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [YW-1:0]           minor;
  logic signed [VALUE_WIDTH-1:0]  acc, acc_base, addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        mat_a[i] <= '0;
        mat_b[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      if (cmd.wr_mat) begin
        mat_b[cmd.wr_addr] <= elem_value[ELEM_WIDTH-1:0];
      end else begin
        mat_a[cmd.wr_addr] <= elem_value[ELEM_WIDTH-1:0];
      end
    end
  end

  assign rd_a = mat_a[cmd.addr_a];
  assign rd_b = mat_b[cmd.addr_b];
  assign x    = cmd.sel ? rd_b : rd_a;

  always_comb begin
    case (cmd.op)
      DP_PROD, DP_MINOR: y = YW'(hold);
      DP_DMAC:           y = minor;
      DP_MAC:            y = YW'(rd_b);
      default:           y = '0;
    endcase
  end

  assign mul      = MW'(x) * MW'(y);
  assign acc_base = cmd.first ? '0 : acc;
  assign addend   = VALUE_WIDTH'(mul);

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_HOLD:  hold  <= x;
      DP_PROD:  prod  <= (2 * ELEM_WIDTH)'(mul);
      DP_MINOR: minor <= YW'(prod) - YW'(mul);
      DP_DMAC, DP_MAC: begin
        acc <= cmd.neg ? (acc_base - addend) : (acc_base + addend);
      end
      DP_ADD:   acc <= VALUE_WIDTH'(rd_a) + VALUE_WIDTH'(rd_b);
      DP_SUB:   acc <= VALUE_WIDTH'(rd_a) - VALUE_WIDTH'(rd_b);
      DP_COPY:  acc <= VALUE_WIDTH'(x);
      default: ;
    endcase
  end

  // The output register frees up in the same cycle as its transfer completes.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_src   <= cmd.out_src;
      out_row   <= cmd.out_row;
      out_col   <= cmd.out_col;
      out_value <= acc;
      out_last  <= cmd.out_last;
    end
  end

endmodule

// ===== tb/tb_matrix3_op_unit.sv =====
// Self-checking testbench for matrix3_op_unit: loads and operations in, result
// transfers checked against a matrix predictor. Depends on m3op_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
  logic              src;
  logic [1:0]        row;
  logic [1:0]        col;
  logic signed [48:0] value;
  logic              last;
} mat_result_t;

class matrix_scoreboard;
  longint      mat_a[9];
  longint      mat_b[9];
  mat_result_t expected_q[$];
  int          failures;

  function new();
    for (int i = 0; i < 9; i++) begin
      mat_a[i] = 0;
      mat_b[i] = 0;
    end
    failures = 0;
  endfunction

  // Keep the low element-width bits and read them as a signed number.
  function longint to_elem(logic [15:0] raw);
    longint span;
    longint v;
    span = 64'sd1 <<< m3op_pkg::ELEM_WIDTH_DEF;
    v = longint'({48'd0, raw}) & (span - 1);
    if (v >= span / 2) v = v - span;
    return v;
  endfunction

  function void push(logic src, int row, int col, longint v, logic last);
    mat_result_t r;
    r.src   = src;
    r.row   = row[1:0];
    r.col   = col[1:0];
    r.value = v[48:0];
    r.last  = last;
    expected_q.push_back(r);
  endfunction

  // Cofactor expansion along the first row.
  function longint det_of(bit use_b);
    longint m[9];
    for (int i = 0; i < 9; i++) m[i] = use_b ? mat_b[i] : mat_a[i];
    return m[0] * (m[4] * m[8] - m[7] * m[5])
         - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  function void note_input(logic [2:0] cmd, logic which, logic [1:0] row,
                           logic [1:0] col, logic [15:0] value);
    longint v;
    int     k;
    k = 0;
    case (cmd)
      m3op_pkg::CMD_LOAD: begin
        if (row != m3op_pkg::IDX_BAD && col != m3op_pkg::IDX_BAD) begin
          if (which) mat_b[row * 3 + col] = to_elem(value);
          else mat_a[row * 3 + col] = to_elem(value);
        end
      end
      m3op_pkg::CMD_MUL, m3op_pkg::CMD_ADD, m3op_pkg::CMD_SUB: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (cmd == m3op_pkg::CMD_MUL) begin
              v = 0;
              for (int i = 0; i < 3; i++) v += mat_a[r * 3 + i] * mat_b[i * 3 + c];
            end else if (cmd == m3op_pkg::CMD_ADD) begin
              v = mat_a[r * 3 + c] + mat_b[r * 3 + c];
            end else begin
              v = mat_a[r * 3 + c] - mat_b[r * 3 + c];
            end
            push(1'b0, r, c, v, k == 8);
            k++;
          end
        end
      end
      m3op_pkg::CMD_DET: begin
        push(1'b0, 0, 0, det_of(1'b0), 1'b0);
        push(1'b1, 0, 0, det_of(1'b1), 1'b1);
      end
      m3op_pkg::CMD_TRN: begin
        for (int m = 0; m < 2; m++) begin
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              v = (m == 0) ? mat_a[c * 3 + r] : mat_b[c * 3 + r];
              push(m[0], r, c, v, k == 17);
              k++;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(mat_result_t got);
    mat_result_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: src %0d row %0d col %0d value %0d last %0d",
                 got.src, got.row, got.col, got.value, got.last);
      return;
    end
    want = expected_q.pop_front();
    if (got.src !== want.src || got.row !== want.row || got.col !== want.col ||
        got.value !== want.value || got.last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display({"mismatch: expected src %0d row %0d col %0d value %0d last %0d,",
                  " got src %0d row %0d col %0d value %0d last %0d"},
                 want.src, want.row, want.col, want.value, want.last,
                 got.src, got.row, got.col, got.value, got.last);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_matrix3_op_unit;
  import m3op_pkg::*;

  localparam logic [2:0] CMD_RSVD6   = 3'd6;
  localparam logic [2:0] CMD_RSVD7   = 3'd7;
  localparam int         RAND_ITEMS  = 300;
  localparam int         IDLE_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 64;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // row_index[1:0], col_index[3:2], elem_value[19:4]
  logic [3:0]  s_tuser;   // cmd[2:0], which_matrix[3]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;   // out_row[1:0], out_col[3:2], out_value[52:4]
  logic [0:0]  m_tuser;   // source_matrix[0]
  logic        m_tlast;

  matrix_scoreboard sb = new();
  mat_result_t      seen;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               sent_items;
  rx_mode_t         rx_mode = RX_OPEN;
  int               rx_mode_left = 0;
  int unsigned      rx_count = 0;

  matrix3_op_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [2:0] cmd, input logic which,
                           input logic [1:0] row, input logic [1:0] col,
                           input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, value, col, row};
    s_tuser  <= {which, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, which, row, col, value);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic [2:0] cmd);
    send_item(cmd, 1'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
  endtask

  // Receiver stall pattern: modes of random length, from always ready to sparse.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= 1'($urandom);
      RX_SPARSE: m_tready <= (rx_count[2:0] == 3'd0);
      default:   m_tready <= (rx_count[1:0] != 2'd3);
    endcase
    rx_count++;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen.src   = m_tuser[0];
        seen.row   = m_tdata[1:0];
        seen.col   = m_tdata[3:2];
        seen.value = m_tdata[52:4];
        seen.last  = m_tlast;
        sb.check_result(seen);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int nloads;
    int op_kind;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: operations on the cleared matrices, extreme elements,
    // every operation, then the items that must leave the state untouched.
    send_op(CMD_DET);
    send_op(CMD_TRN);
    send_item(CMD_LOAD, 1'b0, 2'd0, 2'd0, 16'h8000);
    send_item(CMD_LOAD, 1'b0, 2'd0, 2'd1, 16'h7fff);
    send_item(CMD_LOAD, 1'b0, 2'd1, 2'd1, 16'h8000);
    send_item(CMD_LOAD, 1'b0, IDX_LAST, IDX_LAST, 16'h7fff);
    send_item(CMD_LOAD, 1'b1, 2'd0, 2'd0, 16'h8000);
    send_item(CMD_LOAD, 1'b1, 2'd1, IDX_LAST, 16'h7fff);
    send_item(CMD_LOAD, 1'b1, IDX_LAST, 2'd0, 16'h8000);
    send_item(CMD_LOAD, 1'b1, 2'd0, IDX_LAST, 16'hffff);
    send_op(CMD_MUL);
    send_op(CMD_ADD);
    send_op(CMD_SUB);
    send_op(CMD_DET);
    send_op(CMD_TRN);
    send_item(CMD_LOAD, 1'b0, IDX_BAD, 2'd1, 16'hffff);
    send_item(CMD_LOAD, 1'b1, 2'd1, IDX_BAD, 16'h1234);
    send_item(CMD_LOAD, 1'b1, IDX_BAD, IDX_BAD, 16'h8000);
    send_item(CMD_RSVD6, 1'b1, 2'd0, 2'd0, 16'h7fff);
    send_item(CMD_RSVD7, 1'b0, IDX_BAD, IDX_BAD, 16'hffff);
    send_op(CMD_TRN);
    send_op(CMD_MUL);

    // Random part: mostly loads followed by an operation, some noise.
    sent_items = 0;
    while (sent_items < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0)
            send_item(($urandom_range(0, 1) == 0) ? CMD_RSVD6 : CMD_RSVD7,
                      1'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
          else if ($urandom_range(0, 1) == 0)
            send_item(CMD_LOAD, 1'($urandom), IDX_BAD, 2'($urandom), rand_elem());
          else
            send_item(CMD_LOAD, 1'($urandom), 2'($urandom_range(0, 2)), IDX_BAD,
                      rand_elem());
          sent_items++;
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          // Fill both matrices completely.
          for (int m = 0; m < 2; m++)
            for (int r = 0; r < 3; r++)
              for (int c = 0; c < 3; c++)
                send_item(CMD_LOAD, m[0], r[1:0], c[1:0], rand_elem());
          sent_items += 18;
        end else begin
          nloads = $urandom_range(0, 6);
          repeat (nloads)
            send_item(CMD_LOAD, 1'($urandom), 2'($urandom_range(0, 2)),
                      2'($urandom_range(0, 2)), rand_elem());
          sent_items += nloads;
        end
        op_kind = $urandom_range(CMD_MUL, CMD_TRN);
        send_op(op_kind[2:0]);
        sent_items++;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/m3op_pkg.sv
hdl/m3op_ctrl.sv
hdl/m3op_dpath.sv
hdl/matrix3_op_unit.sv
tb/tb_matrix3_op_unit.sv
